[sv/assert_macros.svh]
// Assertion macros shared by the row store RTL.
// Simulation builds get concurrent assertions on clk_i and rst_ni; synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define HTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true at a clock edge outside reset.
`define HTS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define HTS_ASSERT(lbl, prop, msg)
`define HTS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

[sv/hts_pkg.sv]
// Shared constants, types and a helper function for the Hamming top-k row store.
// Used by hts_row_mem, hts_topk and hamming_topk_row_store_core; depends on nothing.
`timescale 1ns / 1ps

package hts_pkg;

  localparam int ROWS     = 256;
  localparam int SIG_BITS = 64;
  localparam int MAX_K    = 16;

  localparam int ROW_W  = (ROWS > 2) ? $clog2(ROWS) : 1;
  localparam int K_W    = $clog2(MAX_K + 1);
  localparam int KIDX_W = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CNT_W  = 7;
  localparam int LIM_W  = 5;
  localparam int NBYTES = (SIG_BITS + 7) / 8;

  typedef enum logic [2:0] {
    CMD_SET    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_GET    = 3'd2,
    CMD_QUERY  = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GET,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  localparam logic KIND_ROW      = 1'b0;
  localparam logic KIND_NEIGHBOR = 1'b1;

  localparam logic REG_RESULT_LIMIT = 1'b0;
  localparam logic REG_BIT_COUNT    = 1'b1;

  typedef struct packed {
    logic                wr;
    logic                rd;
    logic                inval;
    logic                clr;
    logic [ROW_W-1:0]    addr;
    logic [SIG_BITS-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic                vld;
    logic                hit;
    logic [ROW_W-1:0]    row;
    logic [SIG_BITS-1:0] data;
  } mem_rsp_t;

  typedef struct packed {
    logic                start;
    logic                score;
    logic [K_W-1:0]      k;
    logic [CNT_W-1:0]    bits;
    logic [SIG_BITS-1:0] query;
  } topk_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic [K_W-1:0]   used;
    logic [CNT_W-1:0] cnt;
    logic [ROW_W-1:0] row;
  } topk_stat_t;

  function automatic logic [3:0] popcnt8(input logic [7:0] b);
    logic [3:0] c;
    c = '0;
    for (int i = 0; i < 8; i++) begin
      c = c + 4'(b[i]);
    end
    return c;
  endfunction

endpackage

[sv/hts_row_mem.sv]
// Row storage: a synchronous signature memory plus one valid flip-flop per row.
// Depends on hts_pkg for sizes and the request and response structs.
`timescale 1ns / 1ps

module hts_row_mem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hts_pkg::mem_req_t req_i,
  output hts_pkg::mem_rsp_t rsp_o
);

  logic [hts_pkg::SIG_BITS-1:0] mem_q [hts_pkg::ROWS];
  logic [hts_pkg::ROWS-1:0]     valid_q;
  logic [hts_pkg::SIG_BITS-1:0] rdata_q;
  logic                         rvld_q;
  logic                         rhit_q;
  logic [hts_pkg::ROW_W-1:0]    rrow_q;

  // Vectors have no reset; every read also returns the row's valid bit as the hit flag.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem_q[req_i.addr];
      rhit_q  <= valid_q[req_i.addr];
      rrow_q  <= req_i.addr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= req_i.rd;
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr) begin
        valid_q[req_i.addr] <= 1'b1;
      end else if (req_i.inval) begin
        valid_q[req_i.addr] <= 1'b0;
      end
    end
  end

  assign rsp_o.vld  = rvld_q;
  assign rsp_o.hit  = rhit_q;
  assign rsp_o.row  = rrow_q;
  assign rsp_o.data = rdata_q;

endmodule

[sv/hts_topk.sv]
// Scoring pipeline and sorted k-best list for queries.
// Depends on hts_pkg and assert_macros.svh; fed by the row memory read port.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hts_topk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hts_pkg::topk_ctrl_t         ctrl_i,
  input  hts_pkg::mem_rsp_t           rsp_i,
  input  logic [hts_pkg::KIDX_W-1:0]  emit_idx_i,
  output hts_pkg::topk_stat_t         stat_o
);

  logic [hts_pkg::K_W-1:0]      k_q;
  logic [hts_pkg::SIG_BITS-1:0] mask_q;
  logic [hts_pkg::SIG_BITS-1:0] query_q;
  logic [hts_pkg::SIG_BITS-1:0] mask_d;

  logic                         s1_vld_q;
  logic [hts_pkg::ROW_W-1:0]    s1_row_q;
  logic [3:0]                   s1_bc_q [hts_pkg::NBYTES];
  logic [3:0]                   s1_bc_d [hts_pkg::NBYTES];
  logic                         s2_vld_q;
  logic [hts_pkg::ROW_W-1:0]    s2_row_q;
  logic [hts_pkg::CNT_W-1:0]    s2_cnt_q;
  logic [hts_pkg::CNT_W-1:0]    s2_cnt_d;

  logic [hts_pkg::CNT_W-1:0]    cnt_q [hts_pkg::MAX_K];
  logic [hts_pkg::ROW_W-1:0]    row_q [hts_pkg::MAX_K];
  logic [hts_pkg::CNT_W-1:0]    cnt_d [hts_pkg::MAX_K];
  logic [hts_pkg::ROW_W-1:0]    row_d [hts_pkg::MAX_K];
  logic [hts_pkg::K_W-1:0]      used_q;
  logic [hts_pkg::MAX_K-1:0]    gt;
  logic                         ins_ok;
  logic                         s1_in;

  always_comb begin
    for (int i = 0; i < hts_pkg::SIG_BITS; i++) begin
      mask_d[i] = (hts_pkg::CNT_W'(i) < ctrl_i.bits);
    end
  end

  assign s1_in = rsp_i.vld && rsp_i.hit && ctrl_i.score;

  // Stage one counts agreeing bits per byte; stage two adds the byte counts.
  always_comb begin
    logic [hts_pkg::NBYTES*8-1:0] agree;
    agree = (hts_pkg::NBYTES*8)'(~(query_q ^ rsp_i.data) & mask_q);
    for (int b = 0; b < hts_pkg::NBYTES; b++) begin
      s1_bc_d[b] = hts_pkg::popcnt8(agree[b*8 +: 8]);
    end
  end

  always_comb begin
    s2_cnt_d = '0;
    for (int b = 0; b < hts_pkg::NBYTES; b++) begin
      s2_cnt_d = s2_cnt_d + hts_pkg::CNT_W'(s1_bc_q[b]);
    end
  end

  // Rows arrive in ascending order, so a new entry goes ahead of equal counts:
  // it lands just behind the entries whose count is strictly greater.
  always_comb begin
    for (int i = 0; i < hts_pkg::MAX_K; i++) begin
      gt[i] = (hts_pkg::K_W'(i) < used_q) && (cnt_q[i] > s2_cnt_q);
    end
    ins_ok = (used_q < k_q) || !gt[hts_pkg::KIDX_W'(k_q - hts_pkg::K_W'(1))];
    if (gt[0]) begin
      cnt_d[0] = cnt_q[0];
      row_d[0] = row_q[0];
    end else begin
      cnt_d[0] = s2_cnt_q;
      row_d[0] = s2_row_q;
    end
    for (int i = 1; i < hts_pkg::MAX_K; i++) begin
      if (gt[i]) begin
        cnt_d[i] = cnt_q[i];
        row_d[i] = row_q[i];
      end else if (gt[i-1]) begin
        cnt_d[i] = s2_cnt_q;
        row_d[i] = s2_row_q;
      end else begin
        cnt_d[i] = cnt_q[i-1];
        row_d[i] = row_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      mask_q  <= mask_d;
      query_q <= ctrl_i.query;
    end
    if (s1_in) begin
      s1_row_q <= rsp_i.row;
      s1_bc_q  <= s1_bc_d;
    end
    if (s1_vld_q) begin
      s2_row_q <= s1_row_q;
      s2_cnt_q <= s2_cnt_d;
    end
    if (s2_vld_q && ins_ok) begin
      cnt_q <= cnt_d;
      row_q <= row_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q      <= hts_pkg::K_W'(hts_pkg::MAX_K);
      used_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else if (ctrl_i.start) begin
      k_q      <= ctrl_i.k;
      used_q   <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_in;
      s2_vld_q <= s1_vld_q;
      if (s2_vld_q && ins_ok && (used_q < k_q)) begin
        used_q <= used_q + hts_pkg::K_W'(1);
      end
    end
  end

  assign stat_o.busy = rsp_i.vld | s1_vld_q | s2_vld_q;
  assign stat_o.used = used_q;
  assign stat_o.cnt  = cnt_q[emit_idx_i];
  assign stat_o.row  = row_q[emit_idx_i];

  `HTS_ASSERT(a_used_le_k, used_q <= k_q, "k-best list holds more entries than k")
  `HTS_ASSERT(a_sorted_head, (used_q >= hts_pkg::K_W'(2)) |-> (cnt_q[0] >= cnt_q[1]),
              "k-best list head is out of order")
  `HTS_ASSERT(a_pipe_flow, (s1_vld_q && !ctrl_i.start) |=> s2_vld_q,
              "scored row dropped between pipeline stages")

endmodule

[sv/hamming_topk_row_store_core.sv]
// Top level of the Hamming top-k row store: command sequencer, APB registers, result register.
// Depends on hts_pkg, hts_row_mem, hts_topk and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    cmd_i, row_index_i, signature_i
// result    out        out_valid_o / out_ready_i  kind_o, out_row_o, out_signature_o,
//                                                 found_o, match_count_o, last_o
// config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// Set, remove, clear and unknown commands finish in the cycle the item is accepted.
// A get reads the memory and then loads the result register once it is free.
// A query reads every row once through the single memory read port, then drains the
// scoring pipeline, then emits one neighbor each time the result register is free.
// Reset clears the valid flip-flops at once, so there is no clearing pass after reset.
// A full result register that is not taken stalls the sequencer until it is free.

module hamming_topk_row_store_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  row_index_i,
  input  logic [63:0] signature_i,
  // Result items.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  out_row_o,
  output logic [63:0] out_signature_o,
  output logic        found_o,
  output logic [6:0]  match_count_o,
  output logic        last_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  hts_pkg::state_e state_q, state_d;

  logic [hts_pkg::LIM_W-1:0]  limit_q;
  logic [hts_pkg::CNT_W-1:0]  bits_q;
  logic [hts_pkg::K_W-1:0]    k_sat;
  logic [hts_pkg::CNT_W-1:0]  bits_sat;
  logic                       cfg_wr;

  logic [hts_pkg::ROW_W-1:0]  scan_q;
  logic [hts_pkg::KIDX_W-1:0] emit_q;
  logic [7:0]                 get_row_q;
  logic                       get_inr_q;

  logic        out_vld_q;
  logic        out_kind_q;
  logic [7:0]  out_row_q;
  logic [63:0] out_sig_q;
  logic        out_found_q;
  logic [6:0]  out_cnt_q;
  logic        out_last_q;

  logic                 accept;
  logic                 in_range;
  logic                 query_empty;
  logic                 out_free;
  logic                 out_load;
  logic                 load_get;
  logic                 scan_last;
  logic                 emit_last;
  hts_pkg::cmd_e        cmd;
  hts_pkg::mem_req_t    mem_req;
  hts_pkg::mem_rsp_t    mem_rsp;
  hts_pkg::topk_ctrl_t  tk_ctrl;
  hts_pkg::topk_stat_t  tk_stat;

  // ---------------------------------------------------------------------------
  // Configuration registers. Only paddr[2] selects a register; the low address
  // bits are ignored. Writes must arrive only while idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hts_pkg::LIM_W'(16);
      bits_q  <= hts_pkg::CNT_W'(64);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        hts_pkg::REG_RESULT_LIMIT: limit_q <= pwdata[hts_pkg::LIM_W-1:0];
        hts_pkg::REG_BIT_COUNT:    bits_q  <= pwdata[hts_pkg::CNT_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      hts_pkg::REG_RESULT_LIMIT: prdata = 32'(limit_q);
      hts_pkg::REG_BIT_COUNT:    prdata = 32'(bits_q);
    endcase
  end

  // Values above the supported maxima saturate. A zero in either one makes a
  // query return no neighbors.
  assign k_sat    = (int'(limit_q) > hts_pkg::MAX_K) ? hts_pkg::K_W'(hts_pkg::MAX_K)
                                                    : hts_pkg::K_W'(limit_q);
  assign bits_sat = (int'(bits_q) > hts_pkg::SIG_BITS) ? hts_pkg::CNT_W'(hts_pkg::SIG_BITS)
                                                       : bits_q;
  assign query_empty = (k_sat == '0) || (bits_sat == '0);

  // ---------------------------------------------------------------------------
  // Sequencer. One item is worked on at a time; the result register decouples
  // the sequencer from the consumer so the next item can enter while the last
  // result still waits.
  // ---------------------------------------------------------------------------
  assign cmd       = hts_pkg::cmd_e'(cmd_i);
  assign accept    = in_valid_i && in_ready_o;
  assign in_range  = (int'(row_index_i) < hts_pkg::ROWS);
  assign out_free  = !out_vld_q || out_ready_i;
  assign scan_last = (scan_q == hts_pkg::ROW_W'(hts_pkg::ROWS - 1));
  assign emit_last = ((hts_pkg::K_W'(emit_q) + hts_pkg::K_W'(1)) == tk_stat.used);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hts_pkg::ST_IDLE: begin
        if (accept && (cmd == hts_pkg::CMD_GET)) begin
          state_d = hts_pkg::ST_GET;
        end else if (accept && (cmd == hts_pkg::CMD_QUERY) && !query_empty) begin
          state_d = hts_pkg::ST_SCAN;
        end
      end
      hts_pkg::ST_GET: begin
        if (out_free) begin
          state_d = hts_pkg::ST_IDLE;
        end
      end
      hts_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = hts_pkg::ST_DRAIN;
        end
      end
      hts_pkg::ST_DRAIN: begin
        if (!tk_stat.busy) begin
          state_d = (tk_stat.used == '0) ? hts_pkg::ST_IDLE : hts_pkg::ST_EMIT;
        end
      end
      hts_pkg::ST_EMIT: begin
        if (out_free && emit_last) begin
          state_d = hts_pkg::ST_IDLE;
        end
      end
      default: state_d = hts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    mem_req       = '0;
    mem_req.wdata = hts_pkg::SIG_BITS'(signature_i);
    tk_ctrl       = '0;
    tk_ctrl.k     = k_sat;
    tk_ctrl.bits  = bits_sat;
    tk_ctrl.query = hts_pkg::SIG_BITS'(signature_i);
    out_load      = 1'b0;
    load_get      = 1'b0;
    unique case (state_q)
      hts_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        mem_req.addr = hts_pkg::ROW_W'(row_index_i);
        if (accept) begin
          case (cmd)
            hts_pkg::CMD_SET:    mem_req.wr    = in_range;
            hts_pkg::CMD_REMOVE: mem_req.inval = in_range;
            hts_pkg::CMD_GET:    mem_req.rd    = 1'b1;
            hts_pkg::CMD_QUERY:  tk_ctrl.start = 1'b1;
            hts_pkg::CMD_CLEAR:  mem_req.clr   = 1'b1;
            default:             mem_req.rd    = 1'b0;
          endcase
        end
      end
      hts_pkg::ST_GET: begin
        out_load = out_free;
        load_get = 1'b1;
      end
      hts_pkg::ST_SCAN: begin
        mem_req.rd    = 1'b1;
        mem_req.addr  = scan_q;
        tk_ctrl.score = 1'b1;
      end
      hts_pkg::ST_DRAIN: begin
        tk_ctrl.score = 1'b1;
      end
      hts_pkg::ST_EMIT: begin
        out_load = out_free;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hts_pkg::ST_IDLE;
      scan_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == hts_pkg::ST_SCAN) begin
        scan_q <= scan_q + hts_pkg::ROW_W'(1);
      end else begin
        scan_q <= '0;
      end
      if (state_q != hts_pkg::ST_EMIT) begin
        emit_q <= '0;
      end else if (out_load) begin
        emit_q <= emit_q + hts_pkg::KIDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      get_row_q <= row_index_i;
      get_inr_q <= in_range;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (load_get) begin
        out_kind_q  <= hts_pkg::KIND_ROW;
        out_row_q   <= get_row_q;
        out_found_q <= get_inr_q && mem_rsp.hit;
        out_sig_q   <= (get_inr_q && mem_rsp.hit) ? 64'(mem_rsp.data) : '0;
        out_cnt_q   <= '0;
        out_last_q  <= 1'b1;
      end else begin
        out_kind_q  <= hts_pkg::KIND_NEIGHBOR;
        out_row_q   <= 8'(tk_stat.row);
        out_found_q <= 1'b0;
        out_sig_q   <= '0;
        out_cnt_q   <= 7'(tk_stat.cnt);
        out_last_q  <= emit_last;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign kind_o          = out_kind_q;
  assign out_row_o       = out_row_q;
  assign out_signature_o = out_sig_q;
  assign found_o         = out_found_q;
  assign match_count_o   = out_cnt_q;
  assign last_o          = out_last_q;

  // ---------------------------------------------------------------------------
  // Datapath parts.
  // ---------------------------------------------------------------------------
  hts_row_mem u_row_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mem_req),
    .rsp_o  (mem_rsp)
  );

  hts_topk u_topk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (tk_ctrl),
    .rsp_i      (mem_rsp),
    .emit_idx_i (emit_q),
    .stat_o     (tk_stat)
  );

  `HTS_ASSERT(a_scan_to_drain, (state_q == hts_pkg::ST_SCAN && scan_last) |=>
              (state_q == hts_pkg::ST_DRAIN), "scan did not end after the last row")
  `HTS_ASSERT(a_emit_nonempty, (state_q == hts_pkg::ST_EMIT) |-> (tk_stat.used != '0),
              "emitting from an empty k-best list")
  `HTS_ASSERT(a_row_answer_last, (out_vld_q && out_kind_q == hts_pkg::KIND_ROW) |-> out_last_q,
              "row read answer without last mark")
  `HTS_ASSERT_NEVER(a_emit_busy, (state_q == hts_pkg::ST_EMIT) && tk_stat.busy,
                    "emitting while rows are still being scored")

endmodule
